// ===== rtl/ffcsa_pkg.sv =====
`timescale 1ns / 1ps

package ffcsa_pkg;

   localparam int PATH_W  = 32;
   localparam int COUNT_W = 8;
   localparam int CORE_W  = 3;
   localparam int START_W = 7;

   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [PATH_W-1:0]  path_links;
      logic [COUNT_W-1:0] slot_count;
      logic [CORE_W-1:0]  release_core;
      logic [START_W-1:0] release_start;
   } req_type;

   typedef struct packed {
      logic               granted;
      logic [CORE_W-1:0]  core_used;
      logic [START_W-1:0] first_slot;
      logic [START_W-1:0] last_slot;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_SCAN_END,
      ST_WIN_LOAD,
      ST_WIN_SHIFT,
      ST_FIND,
      ST_MASK,
      ST_WRITE,
      ST_WRITE_END,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic accept;
      logic clear_step;
      logic scan_issue;
      logic write_issue;
      logic win_load;
      logic win_shift;
      logic core_next;
      logic found_load;
      logic mask_load;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic req_ok;
      logic is_release;
      logic link_last;
      logic steps_zero;
      logic win_any;
      logic core_last;
      logic rsp_full;
   } sts_type;

endpackage

// ===== rtl/ffcsa_ctrl.sv =====
`timescale 1ns / 1ps

module ffcsa_ctrl import ffcsa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!sts.req_ok) state_in = ST_RESULT;
            else if (sts.is_release) state_in = ST_MASK;
            else state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.link_last) state_in = ST_SCAN_END;
         end
         ST_SCAN_END:  state_in = ST_WIN_LOAD;
         ST_WIN_LOAD:  state_in = ST_WIN_SHIFT;
         ST_WIN_SHIFT: begin
            if (sts.steps_zero) state_in = ST_FIND;
         end
         ST_FIND: begin
            if (sts.win_any) state_in = ST_MASK;
            else if (sts.core_last) state_in = ST_RESULT;
            else state_in = ST_SCAN;
         end
         ST_MASK: state_in = ST_WRITE;
         ST_WRITE: begin
            if (sts.link_last) state_in = ST_WRITE_END;
         end
         ST_WRITE_END: state_in = ST_RESULT;
         ST_RESULT: begin
            if (!sts.rsp_full) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_SCAN:      cmd.scan_issue = 1'b1;
         ST_WIN_LOAD:  cmd.win_load = 1'b1;
         ST_WIN_SHIFT: cmd.win_shift = !sts.steps_zero;
         ST_FIND: begin
            cmd.found_load = sts.win_any;
            cmd.core_next  = !sts.win_any && !sts.core_last;
         end
         ST_MASK:   cmd.mask_load = 1'b1;
         ST_WRITE:  cmd.write_issue = 1'b1;
         ST_RESULT: cmd.rsp_load = !sts.rsp_full;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/ffcsa_dp.sv =====
`timescale 1ns / 1ps

module ffcsa_dp import ffcsa_pkg::*; #(
   parameter int NUM_LINKS = 32,
   parameter int NUM_CORES = 7,
   parameter int NUM_SLOTS = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word,
   input  cmd_type cmd,
   output sts_type sts
);

   localparam int ROWS = NUM_LINKS * NUM_CORES;
   localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int LW   = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
   localparam int CW   = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
   localparam int SW   = $clog2(NUM_SLOTS);
   localparam int EW   = ($clog2(NUM_SLOTS + 1) > 9) ? $clog2(NUM_SLOTS + 1) : 9;

   function automatic logic [SW-1:0] lowest_set(input logic [NUM_SLOTS-1:0] vec);
      logic [SW-1:0] idx;
      idx = '0;
      for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
         if (vec[s]) idx = SW'(s);
      end
      return idx;
   endfunction

   // One row per (link, core), row index link * NUM_CORES + core.
   logic [NUM_SLOTS-1:0] occ_mem [ROWS];

   logic [NUM_LINKS-1:0] path_vec;
   logic                 kind_ff, kind_in;
   logic [NUM_LINKS-1:0] path_ff, path_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 req_ok_ff, req_ok_in;
   logic [LW-1:0]        link_ff, link_in;
   logic [CW-1:0]        core_ff, core_in;
   logic [SW-1:0]        first_ff, first_in;
   logic [COUNT_W-1:0]   steps_ff, steps_in;
   logic [NUM_SLOTS-1:0] busy_ff, busy_in;
   logic [NUM_SLOTS-1:0] win_ff, win_in;
   logic [NUM_SLOTS-1:0] mask_ff, mask_in;
   logic [NUM_SLOTS-1:0] rdata_ff;
   logic                 scan_pend_ff, scan_pend_in;
   logic                 wr_pend_ff, wr_pend_in;
   logic [AW-1:0]        pend_addr_ff;
   logic [AW-1:0]        clr_ff, clr_in;
   logic                 ok_ff, ok_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [AW-1:0]        row_addr;
   logic                 rd_en;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [NUM_SLOTS-1:0] mem_wdata;
   logic                 link_last;
   logic [EW-1:0]        rel_end;
   logic [EW-1:0]        mask_end;

   // Path bits at or above the link count never reach the table.
   genvar g;
   for (g = 0; g < NUM_LINKS; g++) begin : g_path
      if (g < PATH_W) begin : g_in
         assign path_vec[g] = req_word.path_links[g];
      end else begin : g_out
         assign path_vec[g] = 1'b0;
      end
   end

   assign row_addr  = AW'(link_ff) * AW'(NUM_CORES) + AW'(core_ff);
   assign link_last = (link_ff == LW'(NUM_LINKS - 1));
   assign rel_end   = EW'(req_word.release_start) + EW'(req_word.slot_count);
   assign mask_end  = EW'(first_ff) + EW'(count_ff);

   assign rd_en     = cmd.scan_issue || cmd.write_issue;
   assign mem_we    = cmd.clear_step || wr_pend_ff;
   assign mem_waddr = cmd.clear_step ? clr_ff : pend_addr_ff;
   always_comb begin
      if (cmd.clear_step) begin
         mem_wdata = '0;
      end else if (kind_ff == KIND_ALLOC) begin
         mem_wdata = rdata_ff | mask_ff;
      end else begin
         mem_wdata = rdata_ff & ~mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) rdata_ff <= occ_mem[row_addr];
      if (mem_we) occ_mem[mem_waddr] <= mem_wdata;
   end

   always_comb begin
      kind_in      = kind_ff;
      path_in      = path_ff;
      count_in     = count_ff;
      req_ok_in    = req_ok_ff;
      link_in      = link_ff;
      core_in      = core_ff;
      first_in     = first_ff;
      steps_in     = steps_ff;
      busy_in      = busy_ff;
      win_in       = win_ff;
      mask_in      = mask_ff;
      ok_in        = ok_ff;
      clr_in       = clr_ff;
      scan_pend_in = cmd.scan_issue && path_ff[link_ff];
      wr_pend_in   = cmd.write_issue && path_ff[link_ff];

      if (cmd.clear_step) clr_in = clr_ff + AW'(1);

      if (cmd.accept) begin
         kind_in  = req_word.kind;
         path_in  = path_vec;
         count_in = req_word.slot_count;
         link_in  = '0;
         busy_in  = '0;
         ok_in    = 1'b0;
         first_in = SW'(req_word.release_start);
         core_in  = (req_word.kind == KIND_RELEASE) ? CW'(req_word.release_core) : '0;
         if (req_word.kind == KIND_ALLOC) begin
            req_ok_in = (EW'(req_word.slot_count) <= EW'(NUM_SLOTS));
         end else begin
            req_ok_in = (int'(req_word.release_core) < NUM_CORES) &&
                        (rel_end <= EW'(NUM_SLOTS));
         end
         req_ok_in = req_ok_in && (path_vec != '0) && (req_word.slot_count != '0);
      end

      if (rd_en) link_in = link_last ? '0 : link_ff + LW'(1);

      // Busy slots of the current core, merged over the path links.
      if (scan_pend_ff) busy_in = busy_ff | rdata_ff;

      // After k shifts a set bit marks the start of k + 1 free slots in a row.
      if (cmd.win_load) begin
         win_in   = ~busy_ff;
         steps_in = count_ff - COUNT_W'(1);
      end
      if (cmd.win_shift) begin
         win_in   = win_ff & (win_ff >> 1);
         steps_in = steps_ff - COUNT_W'(1);
      end

      if (cmd.core_next) begin
         core_in = core_ff + CW'(1);
         busy_in = '0;
      end

      if (cmd.found_load) first_in = lowest_set(win_ff);

      if (cmd.mask_load) begin
         ok_in = 1'b1;
         for (int s = 0; s < NUM_SLOTS; s++) begin
            mask_in[s] = (EW'(s) >= EW'(first_ff)) && (EW'(s) < mask_end);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;

      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.granted = ok_ff;
         if (ok_ff) begin
            rsp_in.core_used  = CORE_W'(core_ff);
            rsp_in.first_slot = START_W'(first_ff);
            rsp_in.last_slot  = START_W'(mask_end - EW'(1));
         end else begin
            rsp_in.core_used  = '0;
            rsp_in.first_slot = '0;
            rsp_in.last_slot  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_pend_ff <= 1'b0;
         wr_pend_ff   <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_pend_ff <= scan_pend_in;
         wr_pend_ff   <= wr_pend_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      path_ff      <= path_in;
      count_ff     <= count_in;
      req_ok_ff    <= req_ok_in;
      link_ff      <= link_in;
      core_ff      <= core_in;
      first_ff     <= first_in;
      steps_ff     <= steps_in;
      busy_ff      <= busy_in;
      win_ff       <= win_in;
      mask_ff      <= mask_in;
      ok_ff        <= ok_in;
      pend_addr_ff <= row_addr;
      rsp_ff       <= rsp_in;
   end

   assign sts.clear_last = (clr_ff == AW'(ROWS - 1));
   assign sts.req_ok     = req_ok_ff;
   assign sts.is_release = (kind_ff == KIND_RELEASE);
   assign sts.link_last  = link_last;
   assign sts.steps_zero = (steps_ff == '0);
   assign sts.win_any    = |win_ff;
   assign sts.core_last  = (core_ff == CW'(NUM_CORES - 1));
   assign sts.rsp_full   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_no_clear_over_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear_step && wr_pend_ff))
      else $error("clearing pass collides with a read-modify-write");

   a_scan_write_apart: assert property (@(posedge clock) disable iff (reset)
      !(scan_pend_ff && wr_pend_ff))
      else $error("scan and write-back overlap");

   a_rsp_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("loaded result word is not presented");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result word overwritten before it was taken");

endmodule

// ===== rtl/first_fit_core_spectrum_allocator.sv =====
`timescale 1ns / 1ps

// First-fit spectrum allocator for multicore fiber links. After reset the block
// sweeps all NUM_LINKS * NUM_CORES rows (224 by default) of its occupancy memory
// once, one row per cycle, with req_ready low. A refused word goes straight to
// the result, a release goes straight to the read-modify-write of its rows, and
// an allocate scans and checks each core it tries, followed by the read-modify-
// write when it is granted, or by the result when every core is blocked. A
// result still waiting in the output register holds the next one back in its
// result state until the waiting word is taken. The pace is set by the single
// read port of the occupancy memory, which yields one (link, core) row per cycle
// for the scan and again for the read-modify-write, and by the run check, which
// grows the free run by one slot per cycle. One word is in work at a time; a new
// word is taken while the previous result still waits in the output register.
module first_fit_core_spectrum_allocator import ffcsa_pkg::*; #(
   parameter int NUM_LINKS = 32,
   parameter int NUM_CORES = 7,
   parameter int NUM_SLOTS = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   cmd_type cmd;
   sts_type sts;

   ffcsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffcsa_dp #(
      .NUM_LINKS (NUM_LINKS),
      .NUM_CORES (NUM_CORES),
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
